>>> rtl/ppp_pkg.sv
package ppp_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  typedef struct packed {
    logic valid;
    logic adv;
  } pipe_ctl_t;

endpackage

>>> rtl/ppp_front.sv
module ppp_front
  import ppp_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl_in,
  input  logic                     command,
  input  logic signed [W-1:0]      a_in  [3],
  input  logic signed [W-1:0]      x0_in [3],
  input  logic signed [W-1:0]      x1_in [3],
  output logic                     valid_out,
  output logic [2*W+2:0]           tmag_out,
  output logic [2*W-1:0]           n_out,
  output logic                     zero_out,
  output logic                     cmd_out,
  output logic [W-1:0]             amag_out [3],
  output logic                     flip_out [3],
  output logic signed [W-1:0]      x0_out [3],
  output logic signed [W-1:0]      x1_out [3]
);

  localparam int PW = 2 * W + 1;
  localparam int TW = 2 * W + 3;
  localparam int NW = 2 * W;

  logic [3:0]             v_r;
  logic                   cmd_r [4];
  logic signed [W-1:0]    a_r  [3][3];
  logic signed [W-1:0]    x0_r [4][3];
  logic signed [W-1:0]    x1_r [4][3];
  logic signed [W:0]      d_r  [3];
  logic signed [PW-1:0]   p_r  [3];
  logic signed [NW-1:0]   sq_r [3];
  logic signed [TW-1:0]   t_r;
  logic [NW-1:0]          n_r;
  logic [TW-1:0]          tmag_r;
  logic [NW-1:0]          n4_r;
  logic                   zero_r;
  logic [W-1:0]           amag_r [3];
  logic                   flip_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl_in.adv) begin
      v_r <= {v_r[2:0], ctl_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      cmd_r[0] <= command;
      for (int i = 0; i < 3; i++) begin
        a_r[0][i]  <= a_in[i];
        x0_r[0][i] <= x0_in[i];
        x1_r[0][i] <= x1_in[i];
        d_r[i]     <= (W+1)'(x1_in[i]) - (W+1)'(x0_in[i]);
      end
      for (int s = 1; s < 4; s++) begin
        cmd_r[s] <= cmd_r[s-1];
        for (int i = 0; i < 3; i++) begin
          x0_r[s][i] <= x0_r[s-1][i];
          x1_r[s][i] <= x1_r[s-1][i];
        end
      end
      for (int s = 1; s < 3; s++) begin
        for (int i = 0; i < 3; i++) begin
          a_r[s][i] <= a_r[s-1][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= a_r[0][i] * d_r[i];
        sq_r[i] <= a_r[0][i] * a_r[0][i];
      end
      t_r <= TW'(p_r[0]) + TW'(p_r[1]) + TW'(p_r[2]);
      n_r <= NW'(sq_r[0]) + NW'(sq_r[1]) + NW'(sq_r[2]);
      tmag_r <= t_r[TW-1] ? TW'(-t_r) : TW'(t_r);
      n4_r   <= n_r;
      zero_r <= (n_r == '0);
      for (int i = 0; i < 3; i++) begin
        amag_r[i] <= a_r[2][i][W-1] ? W'(-a_r[2][i]) : W'(a_r[2][i]);
        flip_r[i] <= t_r[TW-1] ^ a_r[2][i][W-1];
      end
    end
  end

  assign valid_out = v_r[3];
  assign tmag_out  = tmag_r;
  assign n_out     = n4_r;
  assign zero_out  = zero_r;
  assign cmd_out   = cmd_r[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag_out[i] = amag_r[i];
      flip_out[i] = flip_r[i];
      x0_out[i]   = x0_r[3][i];
      x1_out[i]   = x1_r[3][i];
    end
  end

endmodule

>>> rtl/ppp_div.sv
module ppp_div
  import ppp_pkg::*;
#(
  parameter int W   = COORD_WIDTH_DEF,
  parameter int SBW = 2 * COORD_WIDTH_DEF + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pipe_ctl_t          ctl_in,
  input  logic [2*W+2:0]     tmag,
  input  logic [W-1:0]       amag,
  input  logic [2*W-1:0]     den,
  input  logic [SBW-1:0]     sb_in,
  output logic               valid_out,
  output logic [W+1:0]       q_out,
  output logic [SBW-1:0]     sb_out
);

  localparam int TW = 2 * W + 3;
  localparam int NW = 2 * W;
  localparam int QW = W + 2;
  localparam int UW = TW + W;
  localparam int CW = (TW + 2) / 3;
  localparam int PPW = CW + W;

  logic [3*CW-1:0]  tpad;
  logic [PPW-1:0]   pp_r [3];
  logic [NW-1:0]    den1_r;
  logic [SBW-1:0]   sb1_r;
  logic             v1_r;
  logic [UW-1:0]    num;

  logic [NW-1:0]    rem_r [QW+1];
  logic [QW-1:0]    low_r [QW+1];
  logic [NW-1:0]    dd_r  [QW+1];
  logic [SBW-1:0]   sbd_r [QW+1];
  logic [QW:0]      vd_r;

  logic [NW:0]      r2   [QW];
  logic             ge   [QW];

  logic [QW-1:0]    q_r;
  logic [SBW-1:0]   sbq_r;
  logic             vq_r;

  assign tpad = (3*CW)'(tmag);
  assign num  = UW'(pp_r[0]) + (UW'(pp_r[1]) << CW) + (UW'(pp_r[2]) << (2*CW));

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      r2[j] = {rem_r[j], low_r[j][QW-1]};
      ge[j] = (r2[j] >= {1'b0, dd_r[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vd_r <= '0;
      vq_r <= 1'b0;
    end else if (ctl_in.adv) begin
      v1_r <= ctl_in.valid;
      vd_r <= {vd_r[QW-1:0], v1_r};
      vq_r <= vd_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      for (int k = 0; k < 3; k++) begin
        pp_r[k] <= PPW'(tpad[k*CW +: CW]) * PPW'(amag);
      end
      den1_r <= den;
      sb1_r  <= sb_in;
      rem_r[0] <= num[QW +: NW];
      low_r[0] <= num[QW-1:0];
      dd_r[0]  <= den1_r;
      sbd_r[0] <= sb1_r;
      for (int j = 0; j < QW; j++) begin
        rem_r[j+1] <= ge[j] ? NW'(r2[j] - {1'b0, dd_r[j]}) : NW'(r2[j]);
        low_r[j+1] <= {low_r[j][QW-2:0], ge[j]};
        dd_r[j+1]  <= dd_r[j];
        sbd_r[j+1] <= sbd_r[j];
      end
      q_r   <= low_r[QW] + QW'(({rem_r[QW], 1'b0} >= {1'b0, dd_r[QW]}));
      sbq_r <= sbd_r[QW];
    end
  end

  assign valid_out = vq_r;
  assign q_out     = q_r;
  assign sb_out    = sbq_r;

endmodule

>>> rtl/ppp_back.sv
module ppp_back
  import ppp_pkg::*;
#(
  parameter int W   = COORD_WIDTH_DEF,
  parameter int SBW = 2 * COORD_WIDTH_DEF + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pipe_ctl_t            ctl_in,
  input  logic [W+1:0]         q [3],
  input  logic [SBW-1:0]       sb [3],
  output logic                 valid_out,
  output logic signed [W-1:0]  res_out [3],
  output logic                 degenerate_out,
  output logic                 saturated_out
);

  localparam int VW = W + 3;
  localparam logic signed [VW-1:0] HI = VW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  logic signed [VW-1:0] qs  [3];
  logic signed [VW-1:0] v   [3];
  logic signed [W-1:0]  res_nxt [3];
  logic                 sat_nxt;
  logic                 zero;
  logic                 cmd;

  logic                 valid_r;
  logic signed [W-1:0]  res_r [3];
  logic                 deg_r;
  logic                 sat_r;

  assign zero = sb[0][SBW-1];
  assign cmd  = sb[0][SBW-2];

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qs[i] = sb[i][2*W] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
      v[i]  = VW'(signed'(sb[i][W-1:0])) - qs[i]
            - (cmd ? VW'(signed'(sb[i][2*W-1:W])) : VW'(0));
      if (v[i] > HI) begin
        res_nxt[i] = HI[W-1:0];
        sat_nxt    = 1'b1;
      end else if (v[i] < LO) begin
        res_nxt[i] = LO[W-1:0];
        sat_nxt    = 1'b1;
      end else begin
        res_nxt[i] = v[i][W-1:0];
      end
      if (zero) begin
        res_nxt[i] = '0;
      end
    end
    if (zero) begin
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_in.adv) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= res_nxt[i];
      end
      deg_r <= zero;
      sat_r <= sat_nxt;
    end
  end

  assign valid_out      = valid_r;
  assign degenerate_out = deg_r;
  assign saturated_out  = sat_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_out[i] = res_r[i];
    end
  end

endmodule

>>> rtl/point_to_plane_projection_unit.sv
// Projects a point onto a plane given by a normal and a point in the plane, in
// signed fixed point; the fraction position does not change the result. One
// transfer is taken every cycle unless the output stalls. A restoring divider
// resolves one quotient bit per stage in each of three lanes. A stall on the
// output while a result is valid freezes the whole pipeline. A zero normal
// returns zeros with degenerate set.
module point_to_plane_projection_unit
  import ppp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic signed [COORD_WIDTH-1:0] in_normal_x,
  input  logic signed [COORD_WIDTH-1:0] in_normal_y,
  input  logic signed [COORD_WIDTH-1:0] in_normal_z,
  input  logic signed [COORD_WIDTH-1:0] in_anchor_x,
  input  logic signed [COORD_WIDTH-1:0] in_anchor_y,
  input  logic signed [COORD_WIDTH-1:0] in_anchor_z,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_result_x,
  output logic signed [COORD_WIDTH-1:0] out_result_y,
  output logic signed [COORD_WIDTH-1:0] out_result_z,
  output logic                          out_degenerate,
  output logic                          out_saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int SBW = 2 * W + 3;

  logic                 adv;
  pipe_ctl_t            ctl_f, ctl_d, ctl_b;
  logic signed [W-1:0]  a_in [3], x0_in [3], x1_in [3];
  logic                 f_valid;
  logic [2*W+2:0]       f_tmag;
  logic [2*W-1:0]       f_n;
  logic                 f_zero, f_cmd;
  logic [W-1:0]         f_amag [3];
  logic                 f_flip [3];
  logic signed [W-1:0]  f_x0 [3], f_x1 [3];
  logic [SBW-1:0]       sb_in [3], sb_out [3];
  logic [W+1:0]         q [3];
  logic                 d_valid [3];
  logic signed [W-1:0]  res [3];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign a_in  = '{in_normal_x, in_normal_y, in_normal_z};
  assign x0_in = '{in_anchor_x, in_anchor_y, in_anchor_z};
  assign x1_in = '{in_point_x, in_point_y, in_point_z};

  assign ctl_f = '{valid: in_valid, adv: adv};
  assign ctl_d = '{valid: f_valid, adv: adv};
  assign ctl_b = '{valid: d_valid[0] & d_valid[1] & d_valid[2], adv: adv};

  ppp_front #(.W(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_f),
    .command   (in_command),
    .a_in      (a_in),
    .x0_in     (x0_in),
    .x1_in     (x1_in),
    .valid_out (f_valid),
    .tmag_out  (f_tmag),
    .n_out     (f_n),
    .zero_out  (f_zero),
    .cmd_out   (f_cmd),
    .amag_out  (f_amag),
    .flip_out  (f_flip),
    .x0_out    (f_x0),
    .x1_out    (f_x1)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign sb_in[i] = {f_zero, f_cmd, f_flip[i], f_x0[i], f_x1[i]};

    ppp_div #(.W(W), .SBW(SBW)) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (ctl_d),
      .tmag      (f_tmag),
      .amag      (f_amag[i]),
      .den       (f_n),
      .sb_in     (sb_in[i]),
      .valid_out (d_valid[i]),
      .q_out     (q[i]),
      .sb_out    (sb_out[i])
    );
  end

  ppp_back #(.W(W), .SBW(SBW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl_in         (ctl_b),
    .q              (q),
    .sb             (sb_out),
    .valid_out      (out_valid),
    .res_out        (res),
    .degenerate_out (out_degenerate),
    .saturated_out  (out_saturated)
  );

  assign out_result_x = res[0];
  assign out_result_y = res[1];
  assign out_result_z = res[2];

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int LAT = CW + 10;
  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 2000;
  localparam int PTW = 2 * CW + 4;
  localparam int PNW = 3 * CW + 8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic   command;
    coord_t nx, ny, nz;
    coord_t ax, ay, az;
    coord_t px, py, pz;
  } query_t;

  typedef struct {
    coord_t rx, ry, rz;
    logic   degen;
    logic   sat;
  } foot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  coord_t in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  coord_t in_anchor_x = '0, in_anchor_y = '0, in_anchor_z = '0;
  coord_t in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_result_x, out_result_y, out_result_z;
  logic out_degenerate, out_saturated;

  point_to_plane_projection_unit #(.COORD_WIDTH(CW)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  foot_t expected_feet[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic foot_t project(query_t q);
    foot_t f;
    logic signed [CW-1:0] a[3], x0[3], x1[3];
    logic signed [2*CW+3:0] t, n;
    logic [2*CW+3:0] tm;
    logic [3*CW+7:0] num, quo, rem;
    logic signed [3*CW+7:0] v;
    coord_t r[3];
    logic [CW-1:0] am;
    a = '{q.nx, q.ny, q.nz};
    x0 = '{q.ax, q.ay, q.az};
    x1 = '{q.px, q.py, q.pz};
    t = '0;
    n = '0;
    f = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      t += PTW'(a[i])
         * PTW'($signed({x1[i][CW-1], x1[i]}) - $signed({x0[i][CW-1], x0[i]}));
      n += PTW'(a[i]) * PTW'(a[i]);
    end
    if (n == 0) begin
      f.degen = 1'b1;
      return f;
    end
    tm = t < 0 ? -t : t;
    for (int i = 0; i < 3; i++) begin
      am = a[i] < 0 ? -a[i] : a[i];
      num = PNW'(tm) * PNW'(am);
      quo = num / PNW'(n);
      rem = num % PNW'(n);
      if ((rem << 1) >= PNW'(n)) quo++;
      v = PNW'(x1[i]);
      if ((t < 0) != (a[i] < 0)) v = v + $signed(quo);
      else v = v - $signed(quo);
      if (q.command) v = v - PNW'(x0[i]);
      if (v > PNW'(CMAX)) begin r[i] = CMAX; f.sat = 1'b1; end
      else if (v < PNW'(CMIN)) begin r[i] = CMIN; f.sat = 1'b1; end
      else r[i] = v[CW-1:0];
    end
    f.rx = r[0];
    f.ry = r[1];
    f.rz = r[2];
    return f;
  endfunction

  task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    foot_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_feet.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          e = expected_feet.pop_front();
          if (out_result_x !== e.rx) report("result_x", out_result_x, e.rx);
          if (out_result_y !== e.ry) report("result_y", out_result_y, e.ry);
          if (out_result_z !== e.rz) report("result_z", out_result_z, e.rz);
          if (out_degenerate !== e.degen)
            report("degenerate", CW'(out_degenerate), CW'(e.degen));
          if (out_saturated !== e.sat)
            report("saturated", CW'(out_saturated), CW'(e.sat));
        end
      end
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (!out_stall && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 512)) - 256) <<< 16;
      2: return coord_t'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return coord_t'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int m;
    m = $urandom_range(0, 3);
    q.command = 1'($urandom);
    q.nx = rand_coord(m); q.ny = rand_coord(m); q.nz = rand_coord(m);
    m = $urandom_range(0, 3);
    q.ax = rand_coord(m); q.ay = rand_coord(m); q.az = rand_coord(m);
    m = $urandom_range(0, 3);
    q.px = rand_coord(m); q.py = rand_coord(m); q.pz = rand_coord(m);
    if ($urandom_range(0, 19) == 0) begin q.nx = 0; q.ny = 0; q.nz = 0; end
    if ($urandom_range(0, 9) == 0) begin q.nx = CMIN; q.ny = CMIN; q.nz = CMIN; end
    return q;
  endfunction

  task automatic send(query_t q, bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= q.command;
    in_normal_x <= q.nx; in_normal_y <= q.ny; in_normal_z <= q.nz;
    in_anchor_x <= q.ax; in_anchor_y <= q.ay; in_anchor_z <= q.az;
    in_point_x <= q.px; in_point_y <= q.py; in_point_z <= q.pz;
    do @(posedge clk); while (in_stall);
    expected_feet.push_back(project(q));
  endtask

  query_t plan[$];
  foot_t given[$];
  bit has_given[$];

  initial begin
    query_t q;
    foot_t z;
    z = '{default: '0};
    q = '{default: '0};
    // zero normal, either command
    plan.push_back(q); z.degen = 1; given.push_back(z); has_given.push_back(1);
    q.command = 1; q.px = CMAX; q.ax = CMIN;
    plan.push_back(q); given.push_back(z); has_given.push_back(1);
    // point already on plane z=0, foot is the point
    q = '{default: '0}; q.nz = 32'sh10000; q.px = CMAX; q.py = CMIN;
    plan.push_back(q); z = '{default: '0}; z.rx = CMAX; z.ry = CMIN;
    given.push_back(z); has_given.push_back(1);
    // foot minus anchor saturates
    q = '{default: '0}; q.command = 1; q.nz = 32'sh10000; q.px = CMAX; q.ax = CMIN;
    plan.push_back(q); z = '{default: '0}; z.rx = CMAX; z.sat = 1;
    given.push_back(z); has_given.push_back(1);
    q.px = CMIN; q.ax = CMAX;
    plan.push_back(q); z.rx = CMIN; given.push_back(z); has_given.push_back(1);
    // extremes and rounding ties, predictor-checked
    q = '{default: '0}; q.nx = 1; q.ny = 1; q.px = 1;
    plan.push_back(q); has_given.push_back(0); given.push_back(z);
    q.px = -1; plan.push_back(q); has_given.push_back(0); given.push_back(z);
    q = '{1'b0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN};
    q.command = 0; plan.push_back(q); has_given.push_back(0); given.push_back(z);
    q.command = 1; plan.push_back(q); has_given.push_back(0); given.push_back(z);
    q = '{1'b1, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
    plan.push_back(q); has_given.push_back(0); given.push_back(z);
    q = '{1'b0, CMIN, 0, 0, CMAX, 5, -5, CMIN, 7, -7};
    plan.push_back(q); has_given.push_back(0); given.push_back(z);
    q = '{1'b0, -1, -1, -1, -1, -1, -1, -1, -1, -1};
    plan.push_back(q); has_given.push_back(0); given.push_back(z);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i]) begin
      send(plan[i], 1'b1);
      if (has_given[i]) begin
        void'(expected_feet.pop_back());
        expected_feet.push_back(given[i]);
      end
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (expected_feet.size() != 0) @(posedge clk);
      end
      if (i == N_RANDOM - 300) quiet = 1'b1;
      send(rand_query(), !quiet);
    end
    in_valid <= 1'b0;
    while (expected_feet.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
